>>> design/bhq_pkg.sv
// Package for the binary min-heap queue: field widths, action codes,
// datapath operation codes and the command and status structs.
// Has no dependencies; every other design file imports it.
package bhq_pkg;

  localparam int KEY_W     = 32;  // width of key_value and top_key on the channels
  localparam int ACT_W     = 2;
  localparam int CNT_OUT_W = 9;   // width of entry_count on the result channel
  localparam int HGT_W     = 4;   // width of tree_height on the result channel

  typedef logic [ACT_W-1:0] act_t;

  localparam act_t ACT_INSERT = 2'd0;
  localparam act_t ACT_REMOVE = 2'd1;
  localparam act_t ACT_CLEAR  = 2'd2;

  // Operations the controller asks of the datapath.
  typedef logic [2:0] op_t;

  localparam op_t OP_NONE    = 3'd0;
  localparam op_t OP_START   = 3'd1;  // take a new item, update count
  localparam op_t OP_UP_READ = 3'd2;  // read the parent of the hole
  localparam op_t OP_UP_STEP = 3'd3;  // move parent down or settle the key
  localparam op_t OP_PUT_KEY = 3'd4;  // write the moving key into the hole
  localparam op_t OP_DN_LOAD = 3'd5;  // latch the former last entry as moving key
  localparam op_t OP_DN_READ = 3'd6;  // read both children of the hole
  localparam op_t OP_DN_STEP = 3'd7;  // move smaller child up or settle the key

  typedef struct packed {
    op_t  op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic one_left;
    logic up_swap;
    logic parent_root;
    logic leaf;
    logic dn_swap;
  } st_t;

endpackage

>>> design/bhq_in_if.sv
// Input channel of the heap queue: valid/ready handshake with action and key.
// Depends on bhq_pkg.
interface bhq_in_if import bhq_pkg::*; ();

  logic             valid;
  logic             ready;
  act_t             action;
  logic [KEY_W-1:0] key_value;

  modport source (output valid, output action, output key_value, input ready);
  modport sink   (input valid, input action, input key_value, output ready);

endinterface

>>> design/bhq_out_if.sv
// Result channel of the heap queue: valid/ready handshake with the result fields.
// Depends on bhq_pkg.
interface bhq_out_if import bhq_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic                 top_valid;
  logic [KEY_W-1:0]     top_key;
  logic [CNT_OUT_W-1:0] entry_count;
  logic [HGT_W-1:0]     tree_height;

  modport source (output valid, output ok, output top_valid, output top_key,
                  output entry_count, output tree_height, input ready);
  modport sink   (input valid, input ok, input top_valid, input top_key,
                  input entry_count, input tree_height, output ready);

endinterface

>>> design/bhq_datapath.sv
// Datapath of the heap queue: key memory, hole position, moving key, count,
// root copy and the result register. Depends on bhq_pkg.
module bhq_datapath import bhq_pkg::*; #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  act_t                 in_action,
  input  logic [KEY_W-1:0]     in_key_value,
  input  cmd_t                 cmd,
  output st_t                  st,
  output logic                 out_ok,
  output logic                 out_top_valid,
  output logic [KEY_W-1:0]     out_top_key,
  output logic [CNT_OUT_W-1:0] out_entry_count,
  output logic [HGT_W-1:0]     out_tree_height
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = AW + 2;
  localparam int HW = $clog2(CW + 1);

  logic [KEY_WIDTH-1:0] heap_mem_r [CAPACITY];
  logic [KEY_WIDTH-1:0] rd_a_r, rd_b_r;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [KEY_WIDTH-1:0] root_r, root_nxt;
  logic [AW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 ok_r, ok_nxt;

  logic                 out_ok_r, out_top_valid_r;
  logic [KEY_W-1:0]     out_top_key_r;
  logic [CNT_OUT_W-1:0] out_entry_count_r;
  logic [HGT_W-1:0]     out_tree_height_r;

  logic [AW-1:0]        parent_pos, pick_pos, rd_a_addr;
  logic [IW-1:0]        left_idx, right_idx, count_idx;
  logic                 take_right, wr_en;
  logic [KEY_WIDTH-1:0] pick_key, wr_data;

  function automatic logic [HW-1:0] bit_len(input logic [CW-1:0] v);
    logic [HW-1:0] n;
    n = '0;
    for (int i = 0; i < CW; i++) begin
      if (v[i]) n = HW'(i + 1);
    end
    return n;
  endfunction

  assign parent_pos = (pos_r - AW'(1)) >> 1;
  assign left_idx   = {1'b0, pos_r, 1'b1};
  assign right_idx  = left_idx + IW'(1);
  assign count_idx  = IW'(count_r);

  // The right child counts only when it lies inside the heap; ties go left.
  assign take_right = (right_idx < count_idx) && (rd_b_r < rd_a_r);
  assign pick_key   = take_right ? rd_b_r : rd_a_r;
  assign pick_pos   = take_right ? right_idx[AW-1:0] : left_idx[AW-1:0];

  assign st.full        = (count_r == CW'(CAPACITY));
  assign st.empty       = (count_r == '0);
  assign st.one_left    = (count_r == CW'(1));
  assign st.up_swap     = (key_r < rd_a_r);
  assign st.parent_root = (parent_pos == '0);
  assign st.leaf        = (left_idx >= count_idx);
  assign st.dn_swap     = (pick_key < key_r);

  always_comb begin
    count_nxt = count_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    ok_nxt    = ok_r;
    wr_en     = 1'b0;
    wr_data   = key_r;
    rd_a_addr = left_idx[AW-1:0];
    unique case (cmd.op)
      OP_START: begin
        // Port A fetches the last entry in case this is a remove.
        rd_a_addr = AW'(count_r - CW'(1));
        case (in_action)
          ACT_INSERT: begin
            ok_nxt = !st.full;
            if (!st.full) begin
              pos_nxt   = count_r[AW-1:0];
              count_nxt = count_r + CW'(1);
              key_nxt   = KEY_WIDTH'(in_key_value);
            end
          end
          ACT_REMOVE: begin
            ok_nxt  = !st.empty;
            pos_nxt = '0;
            if (!st.empty) count_nxt = count_r - CW'(1);
          end
          ACT_CLEAR: begin
            ok_nxt    = 1'b1;
            count_nxt = '0;
          end
          default: ok_nxt = 1'b0;
        endcase
      end
      OP_UP_READ: rd_a_addr = parent_pos;
      OP_UP_STEP: begin
        wr_en   = 1'b1;
        wr_data = st.up_swap ? rd_a_r : key_r;
        if (st.up_swap) pos_nxt = parent_pos;
      end
      OP_PUT_KEY: wr_en = 1'b1;
      OP_DN_LOAD: key_nxt = rd_a_r;
      OP_DN_READ: rd_a_addr = left_idx[AW-1:0];
      OP_DN_STEP: begin
        wr_en   = 1'b1;
        wr_data = st.dn_swap ? pick_key : key_r;
        if (st.dn_swap) pos_nxt = pick_pos;
      end
      default: ;
    endcase
  end

  // The root is mirrored so the result never needs an extra memory read.
  assign root_nxt = (wr_en && pos_r == '0) ? wr_data : root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r  <= pos_nxt;
    key_r  <= key_nxt;
    ok_r   <= ok_nxt;
    root_r <= root_nxt;
    if (cmd.out_load) begin
      out_ok_r          <= ok_r;
      out_top_valid_r   <= (count_r != '0);
      out_top_key_r     <= (count_r != '0) ? KEY_W'(root_r) : '0;
      out_entry_count_r <= CNT_OUT_W'(count_r);
      out_tree_height_r <= HGT_W'(bit_len(count_r));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) heap_mem_r[pos_r] <= wr_data;
    rd_a_r <= heap_mem_r[rd_a_addr];
    rd_b_r <= heap_mem_r[right_idx[AW-1:0]];
  end

  assign out_ok          = out_ok_r;
  assign out_top_valid   = out_top_valid_r;
  assign out_top_key     = out_top_key_r;
  assign out_entry_count = out_entry_count_r;
  assign out_tree_height = out_tree_height_r;

endmodule

>>> design/bhq_ctrl.sv
// Controller of the heap queue: sequences sift-up and sift-down steps and
// owns the input ready and the result valid. Depends on bhq_pkg.
module bhq_ctrl import bhq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  act_t in_action,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  input  st_t  st,
  output cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_UP_RD   = 3'd1;
  localparam logic [2:0] S_UP_CMP  = 3'd2;
  localparam logic [2:0] S_PUT     = 3'd3;
  localparam logic [2:0] S_DN_LOAD = 3'd4;
  localparam logic [2:0] S_DN_RD   = 3'd5;
  localparam logic [2:0] S_DN_CMP  = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_START;
          state_nxt = S_FIN;
          case (in_action)
            ACT_INSERT: begin
              if (!st.full) state_nxt = st.empty ? S_PUT : S_UP_RD;
            end
            ACT_REMOVE: begin
              if (!st.empty && !st.one_left) state_nxt = S_DN_LOAD;
            end
            default: ;
          endcase
        end
      end
      S_UP_RD: begin
        cmd.op    = OP_UP_READ;
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        cmd.op = OP_UP_STEP;
        if (st.up_swap) begin
          state_nxt = st.parent_root ? S_PUT : S_UP_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PUT: begin
        cmd.op    = OP_PUT_KEY;
        state_nxt = S_FIN;
      end
      S_DN_LOAD: begin
        cmd.op    = OP_DN_LOAD;
        state_nxt = S_DN_RD;
      end
      S_DN_RD: begin
        if (st.leaf) begin
          cmd.op    = OP_PUT_KEY;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_DN_READ;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        cmd.op    = OP_DN_STEP;
        state_nxt = st.dn_swap ? S_DN_RD : S_FIN;
      end
      S_FIN: begin
        cmd.out_load = !out_valid_r || out_ready;
        if (cmd.out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/binary_min_heap_queue.sv
// Binary min-heap priority queue; one result beat for every input beat.
// Clear, removing the only entry, failed actions and unused codes go straight to the result.
// One item at a time: the next is taken once the result is registered; a sift level costs a read.
// Reset (synchronous, rst_n low) empties the heap; the key memory itself is not cleared.
module binary_min_heap_queue import bhq_pkg::*; #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WIDTH = 32
) (
  input logic     clk,
  input logic     rst_n,
  bhq_in_if.sink  in_ch,
  bhq_out_if.source out_ch
);

  // The controller and the datapath talk only through these two structs.
  cmd_t cmd;
  st_t  st;

  // The controller decides the sequence of memory reads and writes for each
  // action. An insert places the key in a hole after the last entry and walks
  // the hole up while the key is smaller than the parent. A remove takes the
  // last entry as the moving key, puts the hole at the root and walks it down
  // through the smaller child, preferring the left child on a tie. Each sift
  // level costs a memory read state and then a compare-and-write state.
  bhq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the key memory with one write and two registered read
  // ports, the entry count and a copy of the root key. The result register
  // sits here too, so a finished beat can wait on the output while the input
  // side is already free for the next beat.
  bhq_datapath #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_ch.action),
    .in_key_value    (in_ch.key_value),
    .cmd             (cmd),
    .st              (st),
    .out_ok          (out_ch.ok),
    .out_top_valid   (out_ch.top_valid),
    .out_top_key     (out_ch.top_key),
    .out_entry_count (out_ch.entry_count),
    .out_tree_height (out_ch.tree_height)
  );

endmodule
